[design/sha_pkg.sv]
// Package: SHA-512 constants, state and control types and a rotate-right helper.
package sha_pkg;

  localparam int WordW = 64;
  localparam int NumRounds = 80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
  } comp_ctl_t;

  function automatic logic [63:0] init_value(input logic [2:0] i);
    logic [63:0] r;
    case (i)
      3'd0: r = 64'h6a09e667f3bcc908;
      3'd1: r = 64'hbb67ae8584caa73b;
      3'd2: r = 64'h3c6ef372fe94f82b;
      3'd3: r = 64'ha54ff53a5f1d36f1;
      3'd4: r = 64'h510e527fade682d1;
      3'd5: r = 64'h9b05688c2b3e6c1f;
      3'd6: r = 64'h1f83d9abfb41bd6b;
      default: r = 64'h5be0cd19137e2179;
    endcase
    return r;
  endfunction

  localparam logic [63:0] RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    return (x >> n) | (x << (64 - n));
  endfunction

endpackage

[design/sha_if.sv]
// Interfaces: input byte channel and digest word channel.
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       msg_end;
  modport source (output valid, data_byte, byte_present, msg_end, input ready);
  modport sink (input valid, data_byte, byte_present, msg_end, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  word_index;
  logic        digest_last;
  modport source (output valid, digest_word, word_index, digest_last, input ready);
  modport sink (input valid, digest_word, word_index, digest_last, output ready);
endinterface

[design/sha_round.sv]
// Compression unit: one SHA-512 round per cycle over a rolling schedule.
module sha_round (
  input  logic                clk,
  input  logic                rst,
  input  sha_pkg::comp_ctl_t  ctl,
  input  logic [63:0]         blk [16],
  input  logic [63:0]         chain [8],
  output logic [63:0]         vars [8],
  output logic                done
);
  import sha_pkg::*;

  logic [63:0] w [16];
  logic [6:0]  rnd;
  logic        run;
  logic [63:0] wt, s0, s1, t1, t2, wnew;

  always_comb begin
    s1 = rotr(w[14], 19) ^ rotr(w[14], 61) ^ (w[14] >> 6);
    s0 = rotr(w[1], 1) ^ rotr(w[1], 8) ^ (w[1] >> 7);
    wnew = s1 + w[9] + s0 + w[0];
    wt = (rnd < 7'd16) ? w[rnd[3:0]] : wnew;
    t1 = vars[7] + (rotr(vars[4], 14) ^ rotr(vars[4], 18) ^ rotr(vars[4], 41)) +
         ((vars[4] & vars[5]) ^ (~vars[4] & vars[6])) + RoundK[rnd] + wt;
    t2 = (rotr(vars[0], 28) ^ rotr(vars[0], 34) ^ rotr(vars[0], 39)) +
         ((vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]));
  end

  assign done = run && rnd == 7'(NumRounds - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      rnd <= '0;
    end else if (ctl.start) begin
      run <= 1'b1;
      rnd <= '0;
    end else if (run) begin
      run <= !done;
      rnd <= done ? 7'd0 : rnd + 7'd1;
    end
    if (ctl.start) begin
      w <= blk;
      vars <= chain;
    end else if (run) begin
      if (rnd >= 7'd16) begin
        for (int i = 0; i < 15; i++) w[i] <= w[i+1];
        w[15] <= wnew;
      end
      vars[7] <= vars[6]; vars[6] <= vars[5]; vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2]; vars[2] <= vars[1]; vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end
endmodule

[design/sha512_hash_engine.sv]
// Top level: SHA-512 byte stream hasher with block buffer and sequencer.
//  channel   dir  payload
//  in_ch     in   data_byte[8] byte_present msg_end
//  out_ch    out  digest_word[64] word_index[3] digest_last
// A byte that fills a block holds in_ch through the load, 80 rounds in the
// shared round unit and the add. An end item pads one byte per cycle,
// compresses one or two blocks, then the digest leaves one word per cycle
// when out_ch is ready. Reset (rst, synchronous) restores the IV. in_ch.ready
// is low while a block compresses, pads or the digest drains.
module sha512_hash_engine (
  input  logic clk,
  input  logic rst,
  sha_in_if.sink    in_ch,
  sha_out_if.source out_ch
);
  import sha_pkg::*;

  state_t      state, state_next;
  logic [63:0] blk [16];
  logic [63:0] chain [8];
  logic [63:0] vars [8];
  logic [60:0] nbytes;
  logic [6:0]  fill;
  logic [2:0]  oidx;
  logic        fin, done, put;
  logic        mark, zblk, tail;
  logic [7:0]  pb;
  logic [63:0] bits;
  comp_ctl_t   ctl;

  assign bits = {nbytes, 3'b000};
  sha_round u_round (.clk, .rst, .ctl, .blk, .chain, .vars, .done);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_ch.valid) begin
        if (in_ch.byte_present && fill == 7'd127) state_next = ST_LOAD;
        else if (in_ch.msg_end) state_next = ST_PAD;
      end
      ST_PAD: if (fill == 7'd127) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_ROUND;
      ST_ROUND: if (done) state_next = ST_ADD;
      ST_ADD: state_next = fin ? (tail ? ST_OUT : ST_PAD) : ST_IDLE;
      ST_OUT: if (out_ch.ready && oidx == 3'd7) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = state == ST_IDLE;
    out_ch.valid = state == ST_OUT;
    ctl.start = state == ST_LOAD;
    out_ch.digest_word = chain[oidx];
    out_ch.word_index = oidx;
    out_ch.digest_last = oidx == 3'd7;
    put = 1'b0;
    pb = in_ch.data_byte;
    if (state == ST_IDLE && in_ch.valid && in_ch.byte_present) put = 1'b1;
    if (state == ST_PAD) begin
      put = 1'b1;
      if (mark) pb = 8'h80;
      else if (zblk || fill < 7'd120) pb = 8'h00;
      else pb = bits[8'(7'd127 - fill) * 8 +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      nbytes <= '0;
      fill <= '0;
      oidx <= '0;
      fin <= 1'b0;
      mark <= 1'b0;
      zblk <= 1'b0;
      tail <= 1'b0;
      for (int i = 0; i < 8; i++) chain[i] <= init_value(3'(i));
    end else begin
      state <= state_next;
      if (put) fill <= fill + 7'd1;
      if (state == ST_IDLE && in_ch.valid) begin
        if (in_ch.byte_present) nbytes <= nbytes + 61'd1;
        if (in_ch.msg_end) begin
          fin <= 1'b1;
          mark <= 1'b1;
        end
      end
      if (state == ST_PAD) begin
        if (mark) begin
          mark <= 1'b0;
          if (fill >= 7'd112 && fill != 7'd127) zblk <= 1'b1;
        end else if (!zblk && fill == 7'd127) begin
          tail <= 1'b1;
        end
      end
      if (state == ST_ADD) begin
        for (int i = 0; i < 8; i++) chain[i] <= chain[i] + vars[i];
        zblk <= 1'b0;
      end
      if (state == ST_OUT && out_ch.ready) begin
        oidx <= oidx + 3'd1;
        if (oidx == 3'd7) begin
          for (int i = 0; i < 8; i++) chain[i] <= init_value(3'(i));
          nbytes <= '0;
          fin <= 1'b0;
          tail <= 1'b0;
          fill <= '0;
        end
      end
    end
    if (put) blk[fill[6:3]][8'(3'd7 - fill[2:0]) * 8 +: 8] <= pb;
  end

`ifndef NO_ASSERTIONS
  a_ready: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("ready during digest");
  a_start: assert property (@(posedge clk) disable iff (rst)
    ctl.start |=> state == ST_ROUND) else $error("round start lost");
  a_outfill: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT |-> fill == 7'd0) else $error("digest with partial block");
`endif
endmodule
